>>> rtl/itsu_pkg.sv
// ----------------------------------------------------------------------------
// itsu_pkg
// Shared types and constants for the index table sort unit.
// ----------------------------------------------------------------------------
package itsu_pkg;

    localparam int CAPACITY = 32;                      // cells in the chain, 2..127
    localparam int CNT_W    = $clog2(CAPACITY + 1);    // fill count, holds CAPACITY
    localparam int IDX_W    = $clog2(CAPACITY);        // load index, 0..CAPACITY-1
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int OUT_W    = 8;                       // POS_W padded to a byte

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // insert s_tdata into the chain
        logic shift;    // pop the chain head
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_one; // one entry left
    } status_t;

endpackage

>>> rtl/itsu_ctrl.sv
// ----------------------------------------------------------------------------
// itsu_ctrl
// Load / emit sequencer for the index table sort unit.
// ----------------------------------------------------------------------------
module itsu_ctrl
    import itsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd,
    output logic    s_tready,
    output logic    m_tvalid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_tready && status.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.shift = 1'b0;
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EMIT:
            begin
                m_tvalid  = 1'b1;
                cmd.shift = m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/itsu_datapath.sv
// ----------------------------------------------------------------------------
// itsu_datapath
// Insertion chain of (value, load index) cells kept in ascending order.
// ----------------------------------------------------------------------------
module itsu_datapath
    import itsu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [VAL_W-1:0]    value,
    output status_t             status,
    output logic [POS_W-1:0]    position
);

    logic signed [VAL_W-1:0] cell_val_reg  [CAPACITY];
    logic signed [VAL_W-1:0] cell_val_next [CAPACITY];
    logic [IDX_W-1:0]        cell_idx_reg  [CAPACITY];
    logic [IDX_W-1:0]        cell_idx_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CAPACITY-1:0]     gt;        // cell holds a value above the new one
    logic                    full;
    logic [IDX_W-1:0]        new_idx;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign new_idx = count_reg[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (CNT_W'(i) < count_reg) && (cell_val_reg[i] > $signed(value));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_val_next[i] = cell_val_reg[i];
            cell_idx_next[i] = cell_idx_reg[i];
        end
        if (cmd.load && !full)
        begin
            // ties stay ahead of the new entry: only strictly greater cells move up
            count_next = count_reg + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    cell_val_next[i] = cell_val_reg[(i > 0) ? i - 1 : 0];
                    cell_idx_next[i] = cell_idx_reg[(i > 0) ? i - 1 : 0];
                end
                else if (gt[i] || CNT_W'(i) == count_reg)
                begin
                    cell_val_next[i] = $signed(value);
                    cell_idx_next[i] = new_idx;
                end
            end
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                cell_val_next[i] = cell_val_reg[i + 1];
                cell_idx_next[i] = cell_idx_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_val_reg[i] <= cell_val_next[i];
            cell_idx_reg[i] <= cell_idx_next[i];
        end
    end

    assign status.last_one = (count_reg == CNT_W'(1));
    assign position        = POS_W'(cell_idx_reg[0]) + POS_W'(1);

endmodule

>>> rtl/index_table_sort_unit.sv
// ----------------------------------------------------------------------------
// index_table_sort_unit
// Index table (argsort) over a set of signed 32-bit values, stable on ties.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                     | tlast
//  ---------+-----+---------------------------+-----------------------------
//  s_axis   | in  | [31:0] value (signed)     | final_element, ends the set
//  m_axis   | out | [6:0] position, [7] zero  | final_position, last index
//
//  Load: one beat per cycle; each value goes into a sorted register chain in
//  the cycle it is taken. Emit: after the tlast beat, N result beats (N =
//  values held, at most CAPACITY), one per cycle while m_tready is high, from
//  the chain head; input is stalled during emit. Beats past CAPACITY are
//  dropped, but their tlast still ends the set. Reset (async) empties
//  the chain.
// ----------------------------------------------------------------------------
module index_table_sort_unit
    import itsu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VAL_W-1:0]    s_tdata,    // [31:0] value
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,    // [6:0] position, [7] zero pad
    output logic                m_tlast
);

    cmd_t             cmd;
    status_t          status;
    logic [POS_W-1:0] position;

    itsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    itsu_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value    (s_tdata),
        .status   (status),
        .position (position)
    );

    assign m_tdata = OUT_W'(position);
    assign m_tlast = status.last_one;

`ifndef SYNTH
    // load and emit never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input and output active together");

    // the final result beat hands the unit back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("unit did not return to load after last beat");

    // a beat with tlast always opens an emit phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no results after final element");

    // positions count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] != 7'd0))
        else $error("zero position emitted");
`endif

endmodule

>>> sim/index_table_sort_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_table_sort_unit_test
// Sends sets of signed values through the sort unit with random gaps on both
// streams. A behavioral argsort builds the expected index table for each set,
// and every result beat is checked in order against it.
// ----------------------------------------------------------------------------
module index_table_sort_unit_test
    import itsu_pkg::*;
();

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int TOTAL_BEATS  = 330;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    // value mix for one set
    typedef enum int {
        MIX_FULL,       // any 32-bit pattern
        MIX_TIES,       // few distinct values, many ties
        MIX_EXTREMES,   // min, max, 0, +1, -1
        MIX_FALLING     // strictly descending
    } value_mix_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             final_element;
    } value_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             final_position;
    } index_beat_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata = '0;     // [31:0] value
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // [6:0] position, [7] zero pad
    logic             m_tlast;

    value_beat_t value_beats[$];        // stimulus not yet driven
    index_beat_t expected_positions[$]; // index table entries still to come

    // current set as seen at the input, in load order
    logic signed [VAL_W-1:0] set_values[CAPACITY];
    int                      set_len = 0;

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;

    index_table_sort_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, a few long ones; now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (roll < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(value_mix_t mix, int k, int n);
        int t;
        case (mix)
            MIX_TIES:
            begin
                t = $urandom_range(0, 4);
                return VAL_W'(t - 2);
            end
            MIX_EXTREMES:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            MIX_FALLING:
                return VAL_W'(1000 * (n - 2 * k));
            default:
                return $urandom;
        endcase
    endfunction

    function automatic void push_value(logic [VAL_W-1:0] v, logic last);
        value_beat_t b;
        b.value = v;
        b.final_element = last;
        value_beats.push_back(b);
    endfunction

    function automatic void push_set(int n, value_mix_t mix);
        for (int k = 0; k < n; k++)
            push_value(pick_value(mix, k, n), k == n - 1);
    endfunction

    // Argsort of the held set: stable insertion by signed value, so equal
    // values keep load order. Beats past CAPACITY are dropped, but a final
    // mark on a dropped beat still closes the set.
    function automatic void take_value(logic [VAL_W-1:0] v, logic last);
        int          order[CAPACITY];
        int          j;
        index_beat_t e;
        if (set_len < CAPACITY)
        begin
            set_values[set_len] = v;
            set_len++;
        end
        if (last)
        begin
            for (int i = 0; i < set_len; i++)
            begin
                j = i;
                while (j > 0 && set_values[order[j-1]] > set_values[i])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int k = 0; k < set_len; k++)
            begin
                e.position = POS_W'(order[k] + 1);
                e.final_position = (k == set_len - 1);
                expected_positions.push_back(e);
            end
            set_len = 0;
        end
    endfunction

    // Input driver: next value goes out once the previous beat was taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (value_beats.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= value_beats[0].value;
                s_tlast  <= value_beats[0].final_element;
                void'(value_beats.pop_front());
                send_gap <= pick_gap(send_calm);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side backpressure.
    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            g = pick_gap(recv_calm);
            m_tready <= (g == 0);
            recv_gap <= (g > 0) ? g - 1 : 0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every taken value, check every taken index beat.
    always @(posedge clk)
    begin
        index_beat_t e;
        if (rst_n && s_tvalid && s_tready)
            take_value(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_positions.size() == 0)
            begin
                $display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                e = expected_positions.pop_front();
                if (m_tdata[POS_W-1:0] !== e.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, e.position, m_tdata[POS_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[OUT_W-1:POS_W] !== '0)
                begin
                    $display("%0t: tdata pad expected 0 actual %b",
                             $time, m_tdata[OUT_W-1:POS_W]);
                    mismatch_count++;
                end
                if (m_tlast !== e.final_position)
                begin
                    $display("%0t: final_position expected %b actual %b",
                             $time, e.final_position, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int n;

        // single-element sets at both ends of the range
        push_value(32'h7FFF_FFFF, 1'b1);
        push_value(32'h8000_0000, 1'b1);
        // extremes with ties, including sign boundary
        push_value(32'h0000_0000, 1'b0);
        push_value(32'hFFFF_FFFF, 1'b0);
        push_value(32'h7FFF_FFFF, 1'b0);
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h0000_0001, 1'b0);
        push_value(32'hFFFF_FFFF, 1'b0);
        push_value(32'h0000_0000, 1'b0);
        push_value(32'h7FFF_FFFF, 1'b1);
        // reversed input, then all-equal input
        push_set(5, MIX_FALLING);
        push_value(32'd3, 1'b0);
        push_value(32'd3, 1'b0);
        push_value(32'd3, 1'b1);

        // full store, then overflow where the final beat itself is dropped
        push_set(CAPACITY, MIX_FULL);
        push_set(CAPACITY + 3, MIX_TIES);
        while (value_beats.size() < TOTAL_BEATS)
        begin
            case ($urandom_range(0, 24))
                0, 1:    n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
                2, 3, 4: n = $urandom_range(13, CAPACITY);
                default: n = $urandom_range(1, 12);
            endcase
            push_set(n, value_mix_t'($urandom_range(0, 3)));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (value_beats.size() > 0 || s_tvalid)
            @(negedge clk);
        while (expected_positions.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
